[src/khash_pkg.sv]
// khash_pkg: shared types, constants and round functions of the keyed ARX hash
`timescale 1ns / 1ps
`default_nettype none

package khash_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  len_t;
  typedef logic [2:0]  count_t;

  // four chaining words, index 0 in the low bits
  typedef logic [3:0][31:0] chain_t;

  // one message handed over to finalization
  typedef struct packed {
    chain_t chain;
    word_t  fin_word;
  } fin_item_t;

  // configuration register indexes
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // initialization constants
  localparam word_t INIT0 = 32'h736f6d65;
  localparam word_t INIT1 = 32'h326f7261;
  localparam word_t INIT2 = 32'h6c796765;
  localparam word_t INIT3 = 32'h74653262;

  // xor into chain word 2 at the start of finalization
  localparam word_t FIN_MARK = 32'h000000ff;

  // bytes per full word
  localparam count_t FULL_BYTES = 3'd4;

  function automatic word_t rotl(input word_t x, input int unsigned amt);
    return (x << amt) | (x >> (32 - amt));
  endfunction

  function automatic chain_t init_chain(input word_t k0, input word_t k1);
    chain_t c;
    c[0] = k0 ^ INIT0;
    c[1] = k1 ^ INIT1;
    c[2] = k0 ^ INIT2;
    c[3] = k1 ^ INIT3;
    return c;
  endfunction

  // one round: two half rounds
  function automatic chain_t mix_round(input chain_t c);
    word_t v0;
    word_t v1;
    word_t v2;
    word_t v3;
    chain_t r;
    v0 = c[0];
    v1 = c[1];
    v2 = c[2];
    v3 = c[3];
    // first half round on (v0, v1, v2, v3)
    v0 = v0 + v1;
    v2 = v2 + v3;
    v1 = rotl(v1, 5) ^ v0;
    v3 = rotl(v3, 8) ^ v2;
    v0 = rotl(v0, 16);
    // second half round on (v2, v1, v0, v3)
    v2 = v2 + v1;
    v0 = v0 + v3;
    v1 = rotl(v1, 7) ^ v2;
    v3 = rotl(v3, 13) ^ v0;
    v2 = rotl(v2, 16);
    r[0] = v0;
    r[1] = v1;
    r[2] = v2;
    r[3] = v3;
    return r;
  endfunction

  function automatic chain_t compress(input chain_t c, input word_t m);
    chain_t t;
    t = c;
    t[3] = t[3] ^ m;
    t = mix_round(t);
    t[0] = t[0] ^ m;
    return t;
  endfunction

endpackage

`default_nettype wire

[src/keyed_arx_hash32_stream.sv]
// keyed_arx_hash32_stream: keyed 32-bit ARX stream hash, one word per unstalled cycle
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  s_axis   | s_axis_tvalid/tready   | tdata: data_word, byte_count; tlast: last
//  m_axis   | m_axis_tvalid/tready   | tdata: hash_value
//  cfg      | cfg_we                 | cfg_index, cfg_data (key words)
//
// One word is taken per cycle unless a last word waits on finalization; the
// chaining words go through one round per cycle in the input stage, which is
// the only feedback loop. A last word hands its state to the finalization
// pipeline, whose registers st0 to st3 and result hold while m_axis stalls.
// Output stalls reach s_axis only once the finalization pipeline is full and a
// last word waits; ordinary words never wait on the output.
// Reset (rst, synchronous) clears the keys to zero and all valid flags.

`timescale 1ns / 1ps
`default_nettype none

module keyed_arx_hash32_stream
  import khash_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // data_word [31:0], byte_count [34:32], zeros
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // hash_value [31:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  word_t     key_low;
  word_t     key_high;
  chain_t    chain;
  len_t      len;
  logic      in_v;
  word_t     in_word;
  count_t    in_cnt;
  logic      in_last;
  logic      in_go;
  logic      consume;
  logic      full_word;
  logic      fin_ready;
  chain_t    base_chain;
  count_t    len_inc;
  len_t      len_sum;
  logic [23:0] tail;
  fin_item_t fin_item;

  // input stage can drain unless a last word waits on finalization
  assign in_go         = !in_last || fin_ready;
  assign consume       = in_v && in_go;
  assign s_axis_tready = !in_v || in_go;

  // compression and tail packing
  always_comb begin
    full_word  = !in_last || in_cnt[2];
    base_chain = full_word ? compress(chain, in_word) : chain;
    len_inc    = full_word ? FULL_BYTES : in_cnt;
    len_sum    = len + {5'd0, len_inc};
    case (in_cnt[1:0])
      2'd1:    tail = {16'd0, in_word[7:0]};
      2'd2:    tail = {8'd0, in_word[15:0]};
      2'd3:    tail = in_word[23:0];
      default: tail = 24'd0;
    endcase
    if (full_word) tail = 24'd0;
    fin_item.chain    = base_chain;
    fin_item.fin_word = {len_sum, tail};
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (consume) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word <= s_axis_tdata[31:0];
      in_cnt  <= s_axis_tdata[34:32];
      in_last <= s_axis_tlast;
    end
  end

  // keys, chaining words and length
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      chain    <= init_chain('0, '0);
      len      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW: begin
          key_low <= cfg_data;
          chain   <= init_chain(cfg_data, key_high);
        end
        REG_KEY_HIGH: begin
          key_high <= cfg_data;
          chain    <= init_chain(key_low, cfg_data);
        end
        default: chain <= init_chain(key_low, key_high);
      endcase
      len <= '0;
    end else if (consume) begin
      if (in_last) begin
        chain <= init_chain(key_low, key_high);
        len   <= '0;
      end else begin
        chain <= base_chain;
        len   <= len_sum;
      end
    end
  end

  khash_fin_pipe u_fin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_v && in_last),
    .in_ready  (fin_ready),
    .in_item   (fin_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_hash  (m_axis_tdata)
  );

  // a finished message leaves the chain at the key's start value
  a_reinit_after_last: assert property (@(posedge clk) disable iff (rst)
    (consume && in_last && !cfg_we) |=>
      (chain == init_chain(key_low, key_high) && len == '0))
    else $error("chain not reinitialized after last word");

  // an ordinary word adds four bytes
  a_len_step: assert property (@(posedge clk) disable iff (rst)
    (consume && !in_last && !cfg_we) |=> (len == $past(len) + 8'd4))
    else $error("length did not advance by four");

  // only a waiting last word can hold off the input
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_v && in_last && !fin_ready))
    else $error("input stalled without a blocked last word");

endmodule

`default_nettype wire

[src/khash_fin_pipe.sv]
// khash_fin_pipe: finalization pipeline, input register st0, then one round per stage
`timescale 1ns / 1ps
`default_nettype none

module khash_fin_pipe
  import khash_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire fin_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output word_t          out_hash
);

  fin_item_t st0;
  chain_t    st1;
  chain_t    st2;
  chain_t    st3;
  logic      v0;
  logic      v1;
  logic      v2;
  logic      v3;
  logic      rdy1;
  logic      rdy2;
  logic      rdy3;
  logic      rdy_out;
  chain_t    fin_chain;
  chain_t    last_chain;

  // ready ripples back from the result register
  assign rdy_out  = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = !v0 || rdy1;

  // tail word compression, final marker and last round
  always_comb begin
    fin_chain    = compress(st0.chain, st0.fin_word);
    fin_chain[2] = fin_chain[2] ^ FIN_MARK;
    last_chain   = mix_round(st3);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy_out) out_valid <= v3;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) st0 <= in_item;
    if (rdy1 && v0) st1 <= fin_chain;
    if (rdy2 && v1) st2 <= mix_round(st1);
    if (rdy3 && v2) st3 <= mix_round(st2);
    if (rdy_out && v3) begin
      out_hash <= last_chain[0] ^ last_chain[1] ^ last_chain[2] ^ last_chain[3];
    end
  end

  // backpressure reaches the input only when every stage is full
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v0 && v1 && v2 && v3 && out_valid))
    else $error("finalization input blocked with an empty stage");

  // a stalled last stage keeps its item
  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy_out) |=> (v3 && $stable(st3)))
    else $error("last round stage lost its item under stall");

endmodule

`default_nettype wire
